### hw/rtl/ipfs_pkg.sv
package ipfs_pkg;

   localparam int IMG_SIZE = 256;
   localparam int COL_W    = $clog2(IMG_SIZE);
   localparam int ROW_W    = $clog2(IMG_SIZE + 1);
   localparam int PIX_W    = 8;
   localparam int POS_W    = 8;
   localparam int CNT_W    = 17;

   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(IMG_SIZE - 1);
   localparam logic [ROW_W-1:0] ROW_TRAIL = ROW_W'(IMG_SIZE);
   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [PIX_W-1:0] MIN_INIT  = {PIX_W{1'b1}};
   localparam logic [PIX_W-1:0] MAX_INIT  = '0;

   // accept-side accesses of both line memories
   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] mid_rd_addr;
      logic             mid_wr_en;
      logic [COL_W-1:0] mid_wr_addr;
      logic [PIX_W-1:0] mid_wr_data;
      logic [COL_W-1:0] up_rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      logic             data;
   } up_wr_type;

   // item in the decision stage
   typedef struct packed {
      logic             valid;
      logic             produce;
      logic             clear;
      logic             down;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } stage_type;

endpackage

### hw/rtl/isolated_pixel_filter_stats_unit.sv
// isolated pixel filter with running frame statistics
//
// req channel: one raw pixel per transfer in raster order, frame_start on
// the first pixel of a frame. after the last row the host sends one extra
// row of pixels (values ignored); the position then wraps to a new frame.
// rsp channel: filtered value of the pixel one row above the input, with
// its row, column and the running nonzero count, minimum and maximum of
// the frame. no response during the first row of a frame.
// csr port: csr_write_data is the filter enable (reset 1), written when
// csr_write_enable is high; change it only while the block is idle.
// throughput: one pixel per cycle unless rsp_stall holds the output; the line
// memories take one read and one write per port per cycle. the pixel directly
// below a response goes through the decision stage into the output register.
// reset: position, statistics and the output valid flag clear at once; line
// memories need no clearing since row 0 of every frame fills them.
// when rsp_stall holds the output, one more pixel sits in the decision
// stage and req_stall rises until the output register drains.
module isolated_pixel_filter_stats_unit
   import ipfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic [POS_W-1:0] rsp_out_row,
   output logic [POS_W-1:0] rsp_out_col,
   output logic [CNT_W-1:0] rsp_nonzero_count,
   output logic [PIX_W-1:0] rsp_min_value,
   output logic [PIX_W-1:0] rsp_max_value,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   logic             filter_enable_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   stage_type        stage_ff, stage_in;
   logic [PIX_W-1:0] mid_cur_ff;

   logic             accept, advance;
   logic [ROW_W-1:0] r;
   logic [COL_W-1:0] c;
   logic [PIX_W-1:0] pixel_eff;
   mem_req_type      mem_req;
   up_wr_type        up_wr;
   logic [PIX_W-1:0] mid_rd_data;
   logic             up_rd_data;

   assign req_stall = stage_ff.valid && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      r         = req_frame_start ? '0 : row_ff;
      c         = req_frame_start ? '0 : col_ff;
      pixel_eff = (r == ROW_TRAIL) ? '0 : req_pixel;

      if (c == COL_LAST) begin
         col_in = '0;
         row_in = (r == ROW_TRAIL) ? '0 : r + ROW_W'(1);
      end else begin
         col_in = c + COL_W'(1);
         row_in = r;
      end

      // right neighbour of this pixel is the next read; at the row end the
      // read wraps to entry 0, already holding the row below
      mem_req.rd_en       = accept;
      mem_req.mid_rd_addr = (c == COL_LAST) ? '0 : c + COL_W'(1);
      mem_req.mid_wr_en   = accept;
      mem_req.mid_wr_addr = c;
      mem_req.mid_wr_data = pixel_eff;
      mem_req.up_rd_addr  = c;

      stage_in.valid   = 1'b1;
      stage_in.produce = (r != '0);
      stage_in.clear   = (r == '0) && (c == '0);
      stage_in.down    = (pixel_eff != '0);
      stage_in.row     = r;
      stage_in.col     = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b1;
         row_ff           <= '0;
         col_ff           <= '0;
         stage_ff         <= '0;
      end else begin
         if (csr_write_enable) begin
            filter_enable_ff <= csr_write_data;
         end
         if (accept) begin
            row_ff   <= row_in;
            col_ff   <= col_in;
            stage_ff <= stage_in;
         end else if (advance) begin
            stage_ff.valid <= 1'b0;
         end
      end
   end

   // middle value of this pixel was the right-neighbour read of the previous one
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_cur_ff <= mid_rd_data;
      end
   end

   ipfs_row_mem u_row_mem (
      .clock       (clock),
      .req         (mem_req),
      .up_wr       (up_wr),
      .mid_rd_data (mid_rd_data),
      .up_rd_data  (up_rd_data)
   );

   ipfs_decide u_decide (
      .clock             (clock),
      .reset             (reset),
      .stage             (stage_ff),
      .mid_value         (mid_cur_ff),
      .right_value       (mid_rd_data),
      .up_flag           (up_rd_data),
      .filter_enable     (filter_enable_ff),
      .rsp_stall         (rsp_stall),
      .advance           (advance),
      .up_wr             (up_wr),
      .rsp_valid         (rsp_valid),
      .rsp_out_pixel     (rsp_out_pixel),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_nonzero_count (rsp_nonzero_count),
      .rsp_min_value     (rsp_min_value),
      .rsp_max_value     (rsp_max_value)
   );

`ifndef SYNTHESIS
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= ROW_TRAIL) && (col_ff <= COL_LAST))
      else $error("raster position out of range");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_ff.valid)
      else $error("input stalled with empty decision stage");

   // a frame start may read entry 0 again, row 0 never uses that flag
   a_upper_write_order: assert property (@(posedge clock) disable iff (reset)
      (accept && up_wr.en && !req_frame_start) |-> (up_wr.addr != mem_req.up_rd_addr))
      else $error("upper flag read and written at the same entry");
`endif

endmodule

### hw/rtl/ipfs_row_mem.sv
module ipfs_row_mem
   import ipfs_pkg::*;
(
   input  logic             clock,
   input  mem_req_type      req,
   input  up_wr_type        up_wr,
   output logic [PIX_W-1:0] mid_rd_data,
   output logic             up_rd_data
);

   logic [PIX_W-1:0] mid_mem [IMG_SIZE];
   logic             up_mem  [IMG_SIZE];
   logic [PIX_W-1:0] mid_rd_ff;
   logic             up_rd_ff;

   always_ff @(posedge clock) begin
      if (req.mid_wr_en) begin
         mid_mem[req.mid_wr_addr] <= req.mid_wr_data;
      end
      // read data holds between transfers
      if (req.rd_en) begin
         mid_rd_ff <= mid_mem[req.mid_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (up_wr.en) begin
         up_mem[up_wr.addr] <= up_wr.data;
      end
      if (req.rd_en) begin
         up_rd_ff <= up_mem[req.up_rd_addr];
      end
   end

   assign mid_rd_data = mid_rd_ff;
   assign up_rd_data  = up_rd_ff;

endmodule

### hw/rtl/ipfs_decide.sv
module ipfs_decide
   import ipfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stage_type        stage,
   input  logic [PIX_W-1:0] mid_value,
   input  logic [PIX_W-1:0] right_value,
   input  logic             up_flag,
   input  logic             filter_enable,
   input  logic             rsp_stall,
   output logic             advance,
   output up_wr_type        up_wr,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic [POS_W-1:0] rsp_out_row,
   output logic [POS_W-1:0] rsp_out_col,
   output logic [CNT_W-1:0] rsp_nonzero_count,
   output logic [PIX_W-1:0] rsp_min_value,
   output logic [PIX_W-1:0] rsp_max_value
);

   logic             left_ff, left_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [PIX_W-1:0] max_ff, max_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] pixel_ff;
   logic [POS_W-1:0] row_ff, col_ff;
   logic [CNT_W-1:0] cnt_out_ff;
   logic [PIX_W-1:0] min_out_ff, max_out_ff;

   logic             mid_nz, up_hit, left_hit, right_hit, busy;
   logic [PIX_W-1:0] value;
   logic [CNT_W-1:0] count_base;
   logic [PIX_W-1:0] min_base, max_base;
   logic [ROW_W-1:0] row_above;
   logic             load_out;

   assign advance  = stage.valid && (!rsp_valid_ff || !rsp_stall);
   assign load_out = advance && stage.produce;

   always_comb begin
      mid_nz    = (mid_value != '0);
      up_hit    = (stage.row >= ROW_W'(2)) && up_flag;
      left_hit  = (stage.col != '0) && left_ff;
      right_hit = (stage.col != COL_LAST) && (right_value != '0);
      busy      = stage.down || up_hit || left_hit || right_hit;
      value     = (filter_enable && mid_nz && busy) ? '0 : mid_value;
      row_above = stage.row - ROW_W'(1);

      // the first pixel of a frame restarts the statistics
      count_base = stage.clear ? '0 : count_ff;
      min_base   = stage.clear ? MIN_INIT : min_ff;
      max_base   = stage.clear ? MAX_INIT : max_ff;

      count_in = count_base;
      min_in   = min_base;
      max_in   = max_base;
      if (stage.produce && (value != '0)) begin
         if (count_base != CNT_MAX) begin
            count_in = count_base + CNT_W'(1);
         end
         if (value < min_base) begin
            min_in = value;
         end
         if (value > max_base) begin
            max_in = value;
         end
      end

      left_in = stage.produce ? mid_nz : left_ff;

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end

      up_wr.en   = load_out;
      up_wr.addr = stage.col;
      up_wr.data = mid_nz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= 1'b0;
         count_ff     <= '0;
         min_ff       <= MIN_INIT;
         max_ff       <= MAX_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            left_ff  <= left_in;
            count_ff <= count_in;
            min_ff   <= min_in;
            max_ff   <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         pixel_ff   <= value;
         row_ff     <= row_above[POS_W-1:0];
         col_ff     <= POS_W'(stage.col);
         cnt_out_ff <= count_in;
         min_out_ff <= min_in;
         max_out_ff <= max_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_pixel     = pixel_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_nonzero_count = cnt_out_ff;
   assign rsp_min_value     = min_out_ff;
   assign rsp_max_value     = max_out_ff;

`ifndef SYNTHESIS
   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (min_ff == MIN_INIT && max_ff == MAX_INIT))
      else $error("statistics not at initial values with zero count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum above maximum");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_out)
      else $error("output register overwritten while stalled");
`endif

endmodule
